@@ rtl/itp_pkg.sv @@
package itp_pkg;

  localparam int COUNT_BITS_DEF = 16;
  localparam int VALUE_BITS_DEF = 64;

  localparam int BASE_W     = 6;
  localparam int WIDTH_W    = 16;
  localparam int OFFSET_W   = 16;
  localparam int OUT_VAL_W  = 64;
  localparam int ERR_W      = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_NUMBER_BASE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIGNED_MODE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_WIDTH   = 2'd2;

  localparam logic [BASE_W-1:0]  BASE_AUTO    = 6'd0;
  localparam logic [BASE_W-1:0]  BASE_INVALID = 6'd1;
  localparam logic [BASE_W-1:0]  BASE_MIN     = 6'd2;
  localparam logic [BASE_W-1:0]  BASE_OCTAL   = 6'd8;
  localparam logic [BASE_W-1:0]  BASE_DECIMAL = 6'd10;
  localparam logic [BASE_W-1:0]  BASE_HEX     = 6'd16;
  localparam logic [BASE_W-1:0]  BASE_MAX     = 6'd36;

  localparam logic [WIDTH_W-1:0]  MAX_WIDTH_RESET = 16'hFFFF;
  localparam logic [OFFSET_W-1:0] OFFSET_MAX      = 16'hFFFF;

  localparam logic [ERR_W-1:0] ERR_NONE    = 2'd0;
  localparam logic [ERR_W-1:0] ERR_INVALID = 2'd1;
  localparam logic [ERR_W-1:0] ERR_RANGE   = 2'd2;

  typedef enum logic [2:0] {
    PH_START,
    PH_SPACE,
    PH_SIGN,
    PH_PREFIX,
    PH_AFTER_ZERO,
    PH_DIGITS,
    PH_SKIP,
    PH_DONE
  } phase_t;

  typedef struct packed {
    logic [BASE_W-1:0]  number_base;
    logic               signed_mode;
    logic [WIDTH_W-1:0] max_width;
  } cfg_t;

  typedef struct packed {
    logic              is_space;
    logic              is_plus;
    logic              is_minus;
    logic              is_zero;
    logic              is_x;
    logic              dig_valid;
    logic [BASE_W-1:0] dig;
    logic              last;
  } token_t;

  localparam token_t END_TOKEN = '0;

endpackage

@@ rtl/itp_front.sv @@
module itp_front (
  input  logic                 in_valid,
  input  logic [7:0]           in_ch,
  input  logic                 in_last,
  input  logic                 q_full,
  output logic                 in_stall,
  output logic                 push,
  output itp_pkg::token_t      token
);

  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_PLUS  = 8'd43;
  localparam logic [7:0] CH_MINUS = 8'd45;
  localparam logic [7:0] CH_ZERO  = 8'd48;
  localparam logic [7:0] CH_NINE  = 8'd57;
  localparam logic [7:0] CH_UP_A  = 8'd65;
  localparam logic [7:0] CH_UP_X  = 8'd88;
  localparam logic [7:0] CH_UP_Z  = 8'd90;
  localparam logic [7:0] CH_LO_A  = 8'd97;
  localparam logic [7:0] CH_LO_X  = 8'd120;
  localparam logic [7:0] CH_LO_Z  = 8'd122;
  localparam logic [7:0] LETTER_OFS = 8'd10;

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  always_comb begin
    token           = itp_pkg::END_TOKEN;
    token.last      = in_last;
    token.is_space  = (in_ch == CH_SPACE) || (in_ch >= CH_TAB && in_ch <= CH_CR);
    token.is_plus   = (in_ch == CH_PLUS);
    token.is_minus  = (in_ch == CH_MINUS);
    token.is_zero   = (in_ch == CH_ZERO);
    token.is_x      = (in_ch == CH_LO_X) || (in_ch == CH_UP_X);
    if (in_ch >= CH_ZERO && in_ch <= CH_NINE) begin
      token.dig_valid = 1'b1;
      token.dig       = itp_pkg::BASE_W'(in_ch - CH_ZERO);
    end else if (in_ch >= CH_LO_A && in_ch <= CH_LO_Z) begin
      token.dig_valid = 1'b1;
      token.dig       = itp_pkg::BASE_W'(in_ch - CH_LO_A + LETTER_OFS);
    end else if (in_ch >= CH_UP_A && in_ch <= CH_UP_Z) begin
      token.dig_valid = 1'b1;
      token.dig       = itp_pkg::BASE_W'(in_ch - CH_UP_A + LETTER_OFS);
    end
  end

endmodule

@@ rtl/itp_queue.sv @@
module itp_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  itp_pkg::token_t  push_token,
  input  logic             pop,
  output logic             full,
  output logic             q_valid,
  output itp_pkg::token_t  q_token
);

  localparam int DEPTH = 2;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  itp_pkg::token_t   entry_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r;
  logic [PTR_W-1:0]  rd_ptr_r;
  logic [CNT_W-1:0]  count_r;
  logic [CNT_W-1:0]  count_nxt;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign q_valid = (count_r != '0);
  assign q_token = entry_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_token;
    end
  end

endmodule

@@ rtl/itp_back.sv @@
module itp_back #(
  parameter int COUNT_BITS = itp_pkg::COUNT_BITS_DEF,
  parameter int VALUE_BITS = itp_pkg::VALUE_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  itp_pkg::cfg_t                     cfg,
  input  logic                              q_valid,
  input  itp_pkg::token_t                   q_token,
  output logic                              q_pop,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [itp_pkg::OUT_VAL_W-1:0]     out_value,
  output logic [itp_pkg::OFFSET_W-1:0]      out_end_offset,
  output logic [itp_pkg::ERR_W-1:0]         out_error_code
);

  localparam int BW     = itp_pkg::BASE_W;
  localparam int WW     = itp_pkg::WIDTH_W;
  localparam int PROD_W = VALUE_BITS + BW + 1;
  localparam int POS_W  = (COUNT_BITS > itp_pkg::OFFSET_W) ? COUNT_BITS : itp_pkg::OFFSET_W;

  localparam logic [VALUE_BITS-1:0] TOP_VAL  = {1'b1, {(VALUE_BITS-1){1'b0}}};
  localparam logic [VALUE_BITS-1:0] MAX_POS  = {1'b0, {(VALUE_BITS-1){1'b1}}};
  localparam logic [VALUE_BITS-1:0] ALL_ONES = {VALUE_BITS{1'b1}};
  localparam logic [COUNT_BITS-1:0] POS_SAT  = {COUNT_BITS{1'b1}};

  itp_pkg::phase_t        phase_r, phase_nxt;
  logic                   end_pass_r, end_pass_nxt;
  logic                   mul_pend_r, mul_pend_nxt;
  logic                   neg_r, neg_nxt;
  logic                   sgn_r, sgn_nxt;
  logic [VALUE_BITS-1:0]  acc_r, acc_nxt;
  logic [BW-1:0]          base_r, base_nxt;
  logic [WW-1:0]          wl_r, wl_nxt;
  logic [COUNT_BITS-1:0]  pos_r, pos_nxt;
  logic [itp_pkg::ERR_W-1:0] err_r, err_nxt;
  logic [PROD_W-1:0]      prod_r, prod_nxt;

  logic                   out_valid_r, out_valid_nxt;
  logic [itp_pkg::OUT_VAL_W-1:0] out_value_r;
  logic [itp_pkg::OFFSET_W-1:0]  out_offset_r;
  logic [itp_pkg::ERR_W-1:0]     out_err_r;

  itp_pkg::token_t        cls;
  logic                   finish_req;
  logic                   done_char;
  logic                   pop_c;
  logic                   advance;
  logic                   out_free;
  logic                   wl_pos;
  logic                   dig_ok;
  logic [BW-1:0]          b;
  logic [VALUE_BITS-1:0]  limit;
  logic [VALUE_BITS-1:0]  fin_limit;
  logic [VALUE_BITS-1:0]  fin_val;
  logic [POS_W-1:0]       pos_ext;
  logic [itp_pkg::OFFSET_W-1:0] fin_offset;

  assign out_free = !out_valid_r || !out_stall;
  assign advance  = q_valid && (!finish_req || out_free);
  assign q_pop    = advance && pop_c;

  assign cls    = end_pass_r ? itp_pkg::END_TOKEN : q_token;
  assign wl_pos = (wl_r != '0);
  assign dig_ok = cls.dig_valid && (cls.dig < base_r);
  assign limit  = sgn_r ? (neg_r ? TOP_VAL : MAX_POS) : ALL_ONES;

  always_comb begin
    phase_nxt    = phase_r;
    end_pass_nxt = end_pass_r;
    mul_pend_nxt = mul_pend_r;
    neg_nxt      = neg_r;
    sgn_nxt      = sgn_r;
    acc_nxt      = acc_r;
    base_nxt     = base_r;
    wl_nxt       = wl_r;
    pos_nxt      = pos_r;
    err_nxt      = err_r;
    prod_nxt     = prod_r;
    finish_req   = 1'b0;
    done_char    = 1'b0;
    pop_c        = 1'b0;
    b            = base_r;

    unique case (phase_r)
      itp_pkg::PH_START: begin
        base_nxt = cfg.number_base;
        sgn_nxt  = cfg.signed_mode;
        wl_nxt   = cfg.max_width;
        pos_nxt  = '0;
        neg_nxt  = 1'b0;
        acc_nxt  = '0;
        err_nxt  = itp_pkg::ERR_NONE;
        if (cfg.number_base > itp_pkg::BASE_MAX || cfg.number_base == itp_pkg::BASE_INVALID) begin
          err_nxt    = itp_pkg::ERR_INVALID;
          finish_req = 1'b1;
        end else begin
          phase_nxt = itp_pkg::PH_SPACE;
        end
      end
      itp_pkg::PH_SPACE: begin
        if (cls.is_space) begin
          pos_nxt   = (pos_r == POS_SAT) ? pos_r : pos_r + COUNT_BITS'(1);
          done_char = 1'b1;
        end else begin
          phase_nxt = itp_pkg::PH_SIGN;
        end
      end
      itp_pkg::PH_SIGN: begin
        phase_nxt = itp_pkg::PH_PREFIX;
        if (wl_pos && (cls.is_plus || cls.is_minus)) begin
          neg_nxt   = cls.is_minus;
          pos_nxt   = (pos_r == POS_SAT) ? pos_r : pos_r + COUNT_BITS'(1);
          wl_nxt    = wl_r - WW'(1);
          done_char = 1'b1;
        end
      end
      itp_pkg::PH_PREFIX: begin
        if (wl_pos && cls.is_zero &&
            (base_r == itp_pkg::BASE_AUTO || base_r == itp_pkg::BASE_HEX)) begin
          pos_nxt   = (pos_r == POS_SAT) ? pos_r : pos_r + COUNT_BITS'(1);
          wl_nxt    = wl_r - WW'(1);
          phase_nxt = itp_pkg::PH_AFTER_ZERO;
          done_char = 1'b1;
        end else begin
          if (wl_pos) begin
            b        = (base_r == itp_pkg::BASE_AUTO) ? itp_pkg::BASE_DECIMAL : base_r;
            base_nxt = b;
            if (!cls.dig_valid || cls.dig >= b) begin
              err_nxt = itp_pkg::ERR_INVALID;
            end
          end
          phase_nxt = itp_pkg::PH_DIGITS;
        end
      end
      itp_pkg::PH_AFTER_ZERO: begin
        phase_nxt = itp_pkg::PH_DIGITS;
        if (wl_pos && cls.is_x) begin
          pos_nxt   = (pos_r == POS_SAT) ? pos_r : pos_r + COUNT_BITS'(1);
          wl_nxt    = wl_r - WW'(1);
          base_nxt  = itp_pkg::BASE_HEX;
          done_char = 1'b1;
        end else if (base_r == itp_pkg::BASE_AUTO) begin
          base_nxt = itp_pkg::BASE_OCTAL;
        end
      end
      itp_pkg::PH_DIGITS: begin
        if (wl_pos && dig_ok && base_r >= itp_pkg::BASE_MIN) begin
          if (!mul_pend_r) begin
            prod_nxt     = PROD_W'(acc_r) * PROD_W'(base_r) + PROD_W'(cls.dig);
            mul_pend_nxt = 1'b1;
          end else begin
            mul_pend_nxt = 1'b0;
            if (prod_r <= PROD_W'(limit)) begin
              acc_nxt   = prod_r[VALUE_BITS-1:0];
              pos_nxt   = (pos_r == POS_SAT) ? pos_r : pos_r + COUNT_BITS'(1);
              wl_nxt    = wl_r - WW'(1);
              done_char = 1'b1;
            end else begin
              err_nxt   = itp_pkg::ERR_RANGE;
              phase_nxt = itp_pkg::PH_SKIP;
            end
          end
        end else begin
          finish_req = 1'b1;
        end
      end
      itp_pkg::PH_SKIP: begin
        if (dig_ok) begin
          pos_nxt   = (pos_r == POS_SAT) ? pos_r : pos_r + COUNT_BITS'(1);
          done_char = 1'b1;
        end else begin
          finish_req = 1'b1;
        end
      end
      itp_pkg::PH_DONE: begin
        done_char = 1'b1;
      end
      default: begin
        phase_nxt = itp_pkg::PH_START;
      end
    endcase

    if (finish_req) begin
      phase_nxt = itp_pkg::PH_DONE;
      done_char = 1'b1;
    end

    if (done_char) begin
      if (q_token.last && !end_pass_r && phase_nxt != itp_pkg::PH_DONE) begin
        end_pass_nxt = 1'b1;
      end else begin
        pop_c        = 1'b1;
        end_pass_nxt = 1'b0;
        if (q_token.last) begin
          phase_nxt = itp_pkg::PH_START;
        end
      end
    end
  end

  always_comb begin
    fin_limit = sgn_nxt ? (neg_nxt ? TOP_VAL : MAX_POS) : ALL_ONES;
    if (err_nxt == itp_pkg::ERR_RANGE) begin
      fin_val = fin_limit;
    end else if (neg_nxt) begin
      fin_val = (~acc_nxt) + VALUE_BITS'(1);
    end else begin
      fin_val = acc_nxt;
    end
    pos_ext    = POS_W'(pos_nxt);
    fin_offset = (pos_ext > POS_W'(itp_pkg::OFFSET_MAX)) ? itp_pkg::OFFSET_MAX
                                                          : pos_ext[itp_pkg::OFFSET_W-1:0];
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (advance && finish_req) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= itp_pkg::PH_START;
      end_pass_r  <= 1'b0;
      mul_pend_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (advance) begin
        phase_r    <= phase_nxt;
        end_pass_r <= end_pass_nxt;
        mul_pend_r <= mul_pend_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      neg_r  <= neg_nxt;
      sgn_r  <= sgn_nxt;
      acc_r  <= acc_nxt;
      base_r <= base_nxt;
      wl_r   <= wl_nxt;
      pos_r  <= pos_nxt;
      err_r  <= err_nxt;
      prod_r <= prod_nxt;
    end
    if (advance && finish_req) begin
      out_value_r  <= itp_pkg::OUT_VAL_W'(fin_val);
      out_offset_r <= fin_offset;
      out_err_r    <= err_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_value      = out_value_r;
  assign out_end_offset = out_offset_r;
  assign out_error_code = out_err_r;

endmodule

@@ rtl/integer_text_parser_unit.sv @@
// Channel  Handshake             Payload
// in       in_valid / in_stall   in_ch[7:0], in_last
// out      out_valid / out_stall out_value[63:0], out_end_offset[15:0], out_error_code[1:0]
// cfg      cfg_valid / cfg_ready cfg_index[1:0], cfg_data[15:0]
//
// A character enters a two-entry queue in the cycle it is accepted; the back end's phase
// sequencer then takes it one step at a time, waiting while a finished result cannot enter
// the stalled output register. A taken digit is multiplied by the base, then compared
// against the limit and committed. A string's first character may pass the start, space,
// sign, prefix and digit steps; a final character adds an end-of-string pass.
// rst_n is synchronous and active low; it empties the queue and the result register.
// in_stall rises only when the queue is full; cfg_ready is always high.
module integer_text_parser_unit #(
  parameter int COUNT_BITS = itp_pkg::COUNT_BITS_DEF,
  parameter int VALUE_BITS = itp_pkg::VALUE_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [7:0]                         in_ch,
  input  logic                               in_last,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [itp_pkg::OUT_VAL_W-1:0]      out_value,
  output logic [itp_pkg::OFFSET_W-1:0]       out_end_offset,
  output logic [itp_pkg::ERR_W-1:0]          out_error_code,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [itp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [itp_pkg::CFG_DATA_W-1:0]     cfg_data
);

  itp_pkg::cfg_t   cfg_r;
  itp_pkg::token_t push_token;
  itp_pkg::token_t q_token;
  logic            push;
  logic            q_full;
  logic            q_valid;
  logic            q_pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.number_base <= itp_pkg::BASE_DECIMAL;
      cfg_r.signed_mode <= 1'b1;
      cfg_r.max_width   <= itp_pkg::MAX_WIDTH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        itp_pkg::REG_NUMBER_BASE: cfg_r.number_base <= cfg_data[itp_pkg::BASE_W-1:0];
        itp_pkg::REG_SIGNED_MODE: cfg_r.signed_mode <= cfg_data[0];
        itp_pkg::REG_MAX_WIDTH:   cfg_r.max_width   <= cfg_data[itp_pkg::WIDTH_W-1:0];
        default: ;
      endcase
    end
  end

  itp_front u_front (
    .in_valid (in_valid),
    .in_ch    (in_ch),
    .in_last  (in_last),
    .q_full   (q_full),
    .in_stall (in_stall),
    .push     (push),
    .token    (push_token)
  );

  itp_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_token (push_token),
    .pop        (q_pop),
    .full       (q_full),
    .q_valid    (q_valid),
    .q_token    (q_token)
  );

  itp_back #(
    .COUNT_BITS (COUNT_BITS),
    .VALUE_BITS (VALUE_BITS)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg_r),
    .q_valid        (q_valid),
    .q_token        (q_token),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_value      (out_value),
    .out_end_offset (out_end_offset),
    .out_error_code (out_error_code)
  );

  a_accept_queued: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> q_valid)
    else $error("accepted character missing from queue");

  a_code_known: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_error_code == itp_pkg::ERR_NONE ||
                   out_error_code == itp_pkg::ERR_INVALID ||
                   out_error_code == itp_pkg::ERR_RANGE))
    else $error("undefined error code on result");

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_error_code == itp_pkg::ERR_INVALID |-> out_value == '0)
    else $error("invalid parse with nonzero value");

  a_range_saturated: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_error_code == itp_pkg::ERR_RANGE |->
      (&out_value[VALUE_BITS-2:0]) || !(|out_value[VALUE_BITS-2:0]))
    else $error("range error without saturated value");

endmodule

@@ tb/sv/testbench.sv @@
module testbench;

  localparam logic [8:0]  END_MARK   = 9'h100;
  localparam int          NO_DIGIT   = 255;
  localparam logic [7:0]  CH_PLUS    = 8'h2B;
  localparam logic [7:0]  CH_MINUS   = 8'h2D;
  localparam logic [7:0]  CH_ZERO    = 8'h30;
  localparam logic [7:0]  CH_LOWER_X = 8'h78;
  localparam logic [7:0]  CH_UPPER_X = 8'h58;
  localparam logic [7:0]  CH_SPACE   = 8'h20;
  localparam logic [63:0] SIGNED_TOP = 64'h8000_0000_0000_0000;
  localparam logic [itp_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    logic [itp_pkg::OUT_VAL_W-1:0] value;
    logic [itp_pkg::OFFSET_W-1:0]  end_offset;
    logic [itp_pkg::ERR_W-1:0]     error_code;
  } parse_result_t;

  logic                           clk       = 1'b0;
  logic                           rst_n     = 1'b0;
  logic                           in_valid  = 1'b0;
  logic [7:0]                     in_ch     = 8'd0;
  logic                           in_last   = 1'b0;
  logic                           out_stall = 1'b0;
  logic                           cfg_valid = 1'b0;
  logic [itp_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [itp_pkg::CFG_DATA_W-1:0] cfg_data  = '0;
  logic                           in_stall;
  logic                           out_valid;
  logic [itp_pkg::OUT_VAL_W-1:0]  out_value;
  logic [itp_pkg::OFFSET_W-1:0]   out_end_offset;
  logic [itp_pkg::ERR_W-1:0]      out_error_code;
  logic                           cfg_ready;

  parse_result_t expected_q[$];
  logic [7:0]    text_q[$];
  int            mismatch_count = 0;
  int            chars_sent     = 0;
  bit            idle_en        = 1'b1;
  int            hold_request   = 0;
  int            hold_left      = 0;

  itp_pkg::cfg_t   reg_shadow;
  itp_pkg::phase_t ph;
  logic            neg;
  logic [63:0]     acc;
  logic [5:0]      cur_base;
  logic [15:0]     width_left;
  logic [15:0]     char_pos;
  logic [1:0]      err_flag;
  logic            result_sent;
  logic            signed_parse;

  always #2 clk = ~clk;

  integer_text_parser_unit uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_ch         (in_ch),
    .in_last       (in_last),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_value     (out_value),
    .out_end_offset(out_end_offset),
    .out_error_code(out_error_code),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  function automatic int digit_value(logic [8:0] c);
    if (c >= 9'h30 && c <= 9'h39) return int'(c - 9'h30);
    if (c >= 9'h61 && c <= 9'h7A) return c - 9'h61 + 10;
    if (c >= 9'h41 && c <= 9'h5A) return c - 9'h41 + 10;
    return NO_DIGIT;
  endfunction

  function automatic bit is_blank(logic [8:0] c);
    return c == 9'h20 || (c >= 9'd9 && c <= 9'd13);
  endfunction

  function automatic logic [7:0] digit_char(int v);
    if (v < 10) return 8'h30 + v[7:0];
    if ($urandom_range(1) == 1) return 8'h61 + v[7:0] - 8'd10;
    return 8'h41 + v[7:0] - 8'd10;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("%0t mismatch %s: got %0h, expected %0h", $time, what, got, want);
    mismatch_count++;
  endtask

  task automatic reset_parser();
    reg_shadow.number_base = itp_pkg::BASE_DECIMAL;
    reg_shadow.signed_mode = 1'b1;
    reg_shadow.max_width   = itp_pkg::MAX_WIDTH_RESET;
    ph           = itp_pkg::PH_START;
    neg          = 1'b0;
    acc          = '0;
    cur_base     = '0;
    width_left   = '0;
    char_pos     = '0;
    err_flag     = itp_pkg::ERR_NONE;
    result_sent  = 1'b0;
    signed_parse = 1'b0;
  endtask

  task automatic advance_pos();
    if (char_pos != itp_pkg::OFFSET_MAX) char_pos = char_pos + 16'd1;
  endtask

  task automatic consume_counted();
    advance_pos();
    if (width_left != 0) width_left = width_left - 16'd1;
  endtask

  task automatic emit_result();
    parse_result_t r;
    if (err_flag == itp_pkg::ERR_RANGE) begin
      if (signed_parse) r.value = neg ? SIGNED_TOP : SIGNED_TOP - 64'd1;
      else r.value = {itp_pkg::OUT_VAL_W{1'b1}};
    end else begin
      r.value = neg ? -acc : acc;
    end
    r.end_offset = char_pos;
    r.error_code = err_flag;
    expected_q.push_back(r);
    result_sent = 1'b1;
    ph = itp_pkg::PH_DONE;
  endtask

  task automatic parse_char(logic [8:0] c);
    int          d;
    logic [63:0] dd;
    logic [63:0] lim;
    bit          busy;
    d = digit_value(c);
    dd = 64'(d);
    busy = 1'b1;
    while (busy) begin
      case (ph)
        itp_pkg::PH_START: begin
          cur_base     = reg_shadow.number_base;
          signed_parse = reg_shadow.signed_mode;
          width_left   = reg_shadow.max_width;
          char_pos     = '0;
          neg          = 1'b0;
          acc          = '0;
          err_flag     = itp_pkg::ERR_NONE;
          if (cur_base > itp_pkg::BASE_MAX || cur_base == itp_pkg::BASE_INVALID) begin
            err_flag = itp_pkg::ERR_INVALID;
            emit_result();
            busy = 1'b0;
          end else begin
            ph = itp_pkg::PH_SPACE;
          end
        end
        itp_pkg::PH_SPACE: begin
          if (is_blank(c)) begin
            advance_pos();
            busy = 1'b0;
          end else begin
            ph = itp_pkg::PH_SIGN;
          end
        end
        itp_pkg::PH_SIGN: begin
          ph = itp_pkg::PH_PREFIX;
          if (width_left != 0 && (c == {1'b0, CH_PLUS} || c == {1'b0, CH_MINUS})) begin
            neg = (c == {1'b0, CH_MINUS});
            consume_counted();
            busy = 1'b0;
          end
        end
        itp_pkg::PH_PREFIX: begin
          if (width_left != 0 &&
              (cur_base == itp_pkg::BASE_AUTO || cur_base == itp_pkg::BASE_HEX) &&
              c == {1'b0, CH_ZERO}) begin
            consume_counted();
            ph = itp_pkg::PH_AFTER_ZERO;
            busy = 1'b0;
          end else begin
            if (width_left != 0) begin
              if (cur_base == itp_pkg::BASE_AUTO) cur_base = itp_pkg::BASE_DECIMAL;
              if (d >= cur_base) err_flag = itp_pkg::ERR_INVALID;
            end
            ph = itp_pkg::PH_DIGITS;
          end
        end
        itp_pkg::PH_AFTER_ZERO: begin
          if (width_left != 0 && (c == {1'b0, CH_LOWER_X} || c == {1'b0, CH_UPPER_X})) begin
            consume_counted();
            cur_base = itp_pkg::BASE_HEX;
            ph = itp_pkg::PH_DIGITS;
            busy = 1'b0;
          end else begin
            if (cur_base == itp_pkg::BASE_AUTO) cur_base = itp_pkg::BASE_OCTAL;
            ph = itp_pkg::PH_DIGITS;
          end
        end
        itp_pkg::PH_DIGITS: begin
          if (width_left != 0 && d < cur_base && cur_base >= itp_pkg::BASE_MIN) begin
            if (signed_parse) lim = neg ? SIGNED_TOP : SIGNED_TOP - 64'd1;
            else lim = {64{1'b1}};
            if (acc <= (lim - dd) / cur_base) begin
              acc = acc * cur_base + dd;
              consume_counted();
              busy = 1'b0;
            end else begin
              err_flag = itp_pkg::ERR_RANGE;
              ph = itp_pkg::PH_SKIP;
            end
          end else begin
            emit_result();
            busy = 1'b0;
          end
        end
        itp_pkg::PH_SKIP: begin
          if (d < cur_base) advance_pos();
          else emit_result();
          busy = 1'b0;
        end
        default: busy = 1'b0;
      endcase
    end
  endtask

  task automatic predict_item(logic [7:0] ch, logic last);
    if (!result_sent) parse_char({1'b0, ch});
    if (last) begin
      if (!result_sent) parse_char(END_MARK);
      ph = itp_pkg::PH_START;
      result_sent = 1'b0;
    end
  endtask

  // hold off the result channel, drop stall at random otherwise
  always @(negedge clk) begin
    if (hold_request != 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= idle_en && ($urandom_range(99) < 28);
    end
  end

  always @(posedge clk) begin : result_check
    parse_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected result", out_value, '0);
      end else begin
        want = expected_q.pop_front();
        if (out_value !== want.value)
          report_mismatch("value", out_value, want.value);
        if (out_end_offset !== want.end_offset)
          report_mismatch("end_offset", 64'(out_end_offset), 64'(want.end_offset));
        if (out_error_code !== want.error_code)
          report_mismatch("error_code", 64'(out_error_code), 64'(want.error_code));
      end
    end
  end

  task automatic send_char(logic [7:0] ch, logic last);
    while (idle_en && $urandom_range(99) < 28) begin
      @(negedge clk);
      in_valid <= 1'b0;
      @(posedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_ch    <= ch;
    in_last  <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_item(ch, last);
    chars_sent++;
  endtask

  task automatic send_text();
    for (int i = 0; i < text_q.size(); i++) send_char(text_q[i], i == text_q.size() - 1);
  endtask

  task automatic add_str(string s);
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
  endtask

  task automatic send_str(string s);
    text_q.delete();
    add_str(s);
    send_text();
  endtask

  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic write_reg(logic [itp_pkg::CFG_IDX_W-1:0] idx,
                           logic [itp_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      itp_pkg::REG_NUMBER_BASE: reg_shadow.number_base = data[itp_pkg::BASE_W-1:0];
      itp_pkg::REG_SIGNED_MODE: reg_shadow.signed_mode = data[0];
      itp_pkg::REG_MAX_WIDTH:   reg_shadow.max_width   = data[itp_pkg::WIDTH_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic configure(logic [5:0] base, logic sgn, logic [15:0] width);
    logic [15:0] data;
    settle();
    data = itp_pkg::CFG_DATA_W'($urandom);
    data[5:0] = base;
    write_reg(itp_pkg::REG_NUMBER_BASE, data);
    data = itp_pkg::CFG_DATA_W'($urandom);
    data[0] = sgn;
    write_reg(itp_pkg::REG_SIGNED_MODE, data);
    write_reg(itp_pkg::REG_MAX_WIDTH, width);
  endtask

  task automatic build_random_string();
    int          kind;
    int          gb;
    int          ndig;
    logic [7:0]  w;
    logic [5:0]  b;
    text_q.delete();
    kind = $urandom_range(99);
    b = reg_shadow.number_base;
    gb = (b < itp_pkg::BASE_MIN || b > itp_pkg::BASE_MAX) ? 10 : b;
    if (kind < 15) begin
      repeat ($urandom_range(1, 6)) text_q.push_back(8'($urandom_range(255)));
    end else begin
      repeat ($urandom_range(0, 2)) begin
        w = 8'($urandom_range(8, 13));
        text_q.push_back(w == 8'd8 ? CH_SPACE : w);
      end
      case ($urandom_range(3))
        0: text_q.push_back(CH_PLUS);
        1: text_q.push_back(CH_MINUS);
        default: ;
      endcase
      if ((b == itp_pkg::BASE_AUTO || b == itp_pkg::BASE_HEX) && $urandom_range(99) < 40) begin
        text_q.push_back(CH_ZERO);
        if ($urandom_range(1) == 1) begin
          text_q.push_back($urandom_range(1) == 1 ? CH_LOWER_X : CH_UPPER_X);
          gb = 16;
        end else if (b == itp_pkg::BASE_AUTO) begin
          gb = 8;
        end
      end
      ndig = ($urandom_range(99) < 12) ? $urandom_range(15, 70) : $urandom_range(1, 8);
      repeat (ndig) text_q.push_back(digit_char($urandom_range(gb - 1)));
      if ($urandom_range(99) < 10) text_q.push_back(digit_char($urandom_range(35)));
      if ($urandom_range(99) < 20)
        repeat ($urandom_range(1, 3)) text_q.push_back(8'($urandom_range(255)));
    end
  endtask

  task automatic random_config();
    logic [5:0]  base;
    logic [15:0] width;
    case ($urandom_range(9))
      0: base = itp_pkg::BASE_AUTO;
      1: base = itp_pkg::BASE_HEX;
      2: base = itp_pkg::BASE_OCTAL;
      3: base = itp_pkg::BASE_DECIMAL;
      4: base = itp_pkg::BASE_MIN;
      5: base = itp_pkg::BASE_MAX;
      6: base = itp_pkg::BASE_W'($urandom_range(63));
      default: base = itp_pkg::BASE_W'($urandom_range(2, 36));
    endcase
    case ($urandom_range(9))
      0: width = 16'd0;
      1, 2, 3: width = itp_pkg::WIDTH_W'($urandom_range(1, 24));
      default: width = itp_pkg::MAX_WIDTH_RESET;
    endcase
    configure(base, 1'($urandom_range(1)), width);
  endtask

  task automatic test_defaults();
    logic [7:0] w;
    send_str("0");
    send_str("-42");
    send_str("+7");
    text_q.delete();
    for (w = 8'd9; w <= 8'd13; w++) text_q.push_back(w);
    text_q.push_back(CH_SPACE);
    add_str("15");
    send_text();
    send_str("x");
    send_str("-");
    send_str(" +");
    send_str("12x9");
    text_q.delete();
    text_q.push_back(8'hFF);
    send_text();
    send_str("9223372036854775808");
    send_str("-9223372036854775808");
  endtask

  task automatic test_bases();
    configure(itp_pkg::BASE_AUTO, 1'b1, itp_pkg::MAX_WIDTH_RESET);
    send_str("0x1F");
    send_str("0X");
    send_str("017");
    send_str("09");
    send_str(" -0xff");
    send_str("z");
    configure(itp_pkg::BASE_HEX, 1'b1, itp_pkg::MAX_WIDTH_RESET);
    send_str("0x10");
    send_str("fF");
    send_str("0xg");
    configure(itp_pkg::BASE_INVALID, 1'b1, itp_pkg::MAX_WIDTH_RESET);
    send_str("5");
    configure(6'd37, 1'b0, itp_pkg::MAX_WIDTH_RESET);
    send_str("1");
    configure(6'd63, 1'b1, itp_pkg::MAX_WIDTH_RESET);
    send_str("12");
    configure(itp_pkg::BASE_MAX, 1'b0, itp_pkg::MAX_WIDTH_RESET);
    send_str("zzzzzzzzzzzzz");
    send_str("-Zz");
    configure(itp_pkg::BASE_MIN, 1'b1, itp_pkg::MAX_WIDTH_RESET);
    send_str("-101");
    send_str("102");
    configure(itp_pkg::BASE_DECIMAL, 1'b0, itp_pkg::MAX_WIDTH_RESET);
    send_str("-1");
    send_str("18446744073709551615");
    send_str("-18446744073709551616");
    settle();
    write_reg(REG_UNUSED, itp_pkg::CFG_DATA_W'($urandom));
    send_str("3");
  endtask

  task automatic test_widths();
    configure(itp_pkg::BASE_DECIMAL, 1'b1, 16'd0);
    send_str("5");
    configure(itp_pkg::BASE_DECIMAL, 1'b1, 16'd1);
    send_str("-5");
    configure(itp_pkg::BASE_DECIMAL, 1'b1, 16'd3);
    send_str("  -1234");
    configure(itp_pkg::BASE_DECIMAL, 1'b1, 16'd20);
    send_str("99999999999999999999999");
    configure(itp_pkg::BASE_AUTO, 1'b1, 16'd2);
    send_str("0x5");
    configure(itp_pkg::BASE_AUTO, 1'b0, 16'd1);
    send_str("0x");
  endtask

  task automatic test_quiet_stretch();
    int stop_at;
    configure(itp_pkg::BASE_AUTO, 1'b1, itp_pkg::MAX_WIDTH_RESET);
    idle_en = 1'b0;
    stop_at = chars_sent + 80;
    while (chars_sent < stop_at) begin
      build_random_string();
      send_text();
    end
    settle();
    idle_en = 1'b1;
  endtask

  task automatic test_backpressure();
    configure(itp_pkg::BASE_DECIMAL, 1'b1, itp_pkg::MAX_WIDTH_RESET);
    hold_request = 300;
    repeat (30) begin
      if ($urandom_range(1) == 1) send_str("7");
      else send_str("-3");
    end
  endtask

  task automatic test_random_strings();
    int stop_at;
    int phase_end;
    stop_at = chars_sent + 130;
    while (chars_sent < stop_at) begin
      random_config();
      phase_end = chars_sent + 26;
      while (chars_sent < phase_end) begin
        build_random_string();
        send_text();
      end
    end
  endtask

  initial begin
    reset_parser();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_defaults();
    test_bases();
    test_widths();
    test_quiet_stretch();
    test_backpressure();
    test_random_strings();
    settle();
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #8000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/itp_pkg.sv
rtl/itp_front.sv
rtl/itp_queue.sv
rtl/itp_back.sv
rtl/integer_text_parser_unit.sv
tb/sv/testbench.sv
